@@ design/cpa_pkg.sv @@
package cpa_pkg;

	// Request kinds.
	localparam logic [1:0] MODE_ALLOC     = 2'd0;
	localparam logic [1:0] MODE_RELEASE   = 2'd1;
	localparam logic [1:0] MODE_TRANSLATE = 2'd2;

	// Status codes.
	localparam logic [1:0] ST_OK      = 2'd0;
	localparam logic [1:0] ST_NO_ROOM = 2'd1;
	localparam logic [1:0] ST_UNKNOWN = 2'd2;

	typedef struct packed {
		logic [1:0] mode;
		logic [7:0] pid;
		logic [6:0] page_count;
		logic [5:0] page_index;
	} req_t;

	typedef struct packed {
		logic [1:0] status;
		logic [5:0] base_page;
		logic       is_move;
		logic [5:0] move_from;
		logic [5:0] move_to;
		logic       last;
	} rsp_t;

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic load;        // capture the request
		logic proc_clr;    // clear the process scan
		logic proc_step;   // examine one table entry
		logic page_clr;    // reset page pointers
		logic scan_step;   // one page of the hole scan
		logic cmp_step;    // one page of compaction
		logic fill_step;   // one page of reservation
		logic rel_step;    // one page of release
		logic xl_step;     // one page of the first-page search
		logic commit;      // write the process table entry
		logic rel_commit;  // free the process table entry
	} cmd_t;

	// Status from the datapath to the controller.
	typedef struct packed {
		logic       proc_done;
		logic       proc_hit;
		logic       slot_free;
		logic       page_done;
		logic       fit_found;
		logic       total_ok;
		logic       cnt_zero;
		logic       fill_done;
		logic       idx_ok;
		logic       move_now;
		logic [1:0] mode;
	} sts_t;

endpackage

@@ design/cpa_stream_if.sv @@
interface cpa_stream_if #(
	parameter int W = 8
) ();
	logic         valid;
	logic         ready;
	logic [W-1:0] data;

	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

@@ design/contiguous_page_allocator.sv @@
// Contiguous swap-page allocator, first fit with compaction.
// Requests arrive on the req channel (valid/ready, mode, pid, page_count,
// page_index) and results leave on the rsp channel. One request is taken at
// a time; ready is high only while the block is idle.
// A request first walks the process table, one entry a cycle, and
// decides. Release and translate then walk the whole map. An allocate
// of one page or more scans the managed pages one a cycle and reserves
// its run one page a cycle; when compaction is needed it walks the
// managed pages again, emitting one move result per relocated page
// before the final one.
// The last result of every request has last=1.
// Each result is held until the receiver takes it; the walk pauses while a
// move result is stalled, so nothing is lost.
// The cfg port writes pages_in_use; the user must write it only while
// idle, as the block itself does not enforce this. Reset empties the page
// map and the process table and sets pages_in_use to 64; no clearing pass.
module contiguous_page_allocator #(
	parameter int NUM_PAGES = 64,
	parameter int MAX_PROCS = 16
) (
	input  logic       clk,
	input  logic       arst_n,
	cpa_stream_if.sink   req,
	cpa_stream_if.source rsp,
	input  logic       cfg_we,
	input  logic [6:0] cfg_data
);
	cpa_pkg::cmd_t cmd;
	cpa_pkg::sts_t sts;
	cpa_pkg::rsp_t r;
	logic [5:0]    base_out;
	logic [5:0]    mv_from;
	logic [5:0]    mv_to;
	logic [1:0]    rsp_status;
	logic          rsp_move;
	logic          rsp_base_en;

	cpa_ctrl u_ctrl (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (req.valid),
		.in_ready    (req.ready),
		.out_valid   (rsp.valid),
		.out_ready   (rsp.ready),
		.cmd         (cmd),
		.sts         (sts),
		.rsp_status  (rsp_status),
		.rsp_move    (rsp_move),
		.rsp_base_en (rsp_base_en)
	);

	cpa_datapath #(
		.NUM_PAGES (NUM_PAGES),
		.MAX_PROCS (MAX_PROCS)
	) u_dp (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_we   (cfg_we),
		.cfg_data (cfg_data),
		.req      (cpa_pkg::req_t'(req.data)),
		.cmd      (cmd),
		.sts      (sts),
		.base_out (base_out),
		.mv_from  (mv_from),
		.mv_to    (mv_to)
	);

	// Result assembly.
	always_comb begin
		r.status    = rsp_status;
		r.base_page = rsp_base_en ? base_out : 6'd0;
		r.is_move   = rsp_move;
		r.move_from = rsp_move ? mv_from : 6'd0;
		r.move_to   = rsp_move ? mv_to : 6'd0;
		r.last      = !rsp_move;
	end

	assign rsp.data = r;
endmodule

@@ design/cpa_datapath.sv @@
module cpa_datapath #(
	parameter int NUM_PAGES = 64,
	parameter int MAX_PROCS = 16
) (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            cfg_we,
	input  logic [6:0]      cfg_data,
	input  cpa_pkg::req_t   req,
	input  cpa_pkg::cmd_t   cmd,
	output cpa_pkg::sts_t   sts,
	output logic [5:0]      base_out,
	output logic [5:0]      mv_from,
	output logic [5:0]      mv_to
);
	localparam int PW = $clog2(NUM_PAGES);
	localparam int SW = (MAX_PROCS > 1) ? $clog2(MAX_PROCS) : 1;
	localparam int PC = PW + 1;
	localparam int SC = $clog2(MAX_PROCS + 1);

	logic [6:0]           pages_cfg_q;
	cpa_pkg::req_t        req_q;
	logic [NUM_PAGES-1:0] used_q;
	logic [7:0]           owner_q [NUM_PAGES];
	logic [MAX_PROCS-1:0] pvalid_q;
	logic [7:0]           pid_mem_q [MAX_PROCS];
	logic [6:0]           ppages_q [MAX_PROCS];

	logic [SC-1:0]        pi_q;
	logic                 hit_q;
	logic [SW-1:0]        hit_slot_q;
	logic                 free_q;
	logic [SW-1:0]        free_slot_q;
	logic [6:0]           hit_pages_q;

	logic [PC-1:0]        i_q;
	logic [PC-1:0]        w_q;
	logic [6:0]           run_q;
	logic [6:0]           total_q;
	logic                 found_q;
	logic [PC-1:0]        base_q;
	logic                 first_q;
	logic [PC-1:0]        first_pg_q;
	logic [5:0]           from_q;
	logic [5:0]           to_q;
	logic [7:0]           own_rd_q;

	logic [6:0]           eff;
	logic [PW-1:0]        ip;
	logic [SW-1:0]        ps;
	logic [6:0]           run_n;
	logic [PC-1:0]        fill_pg;
	logic [PC-1:0]        i_nxt;
	logic                 in_scope;
	logic                 walk_last;

	// Effective number of managed pages.
	assign eff = (pages_cfg_q > 7'(NUM_PAGES)) ? 7'(NUM_PAGES) : pages_cfg_q;
	assign ip  = i_q[PW-1:0];
	assign ps  = pi_q[SW-1:0];
	assign run_n = run_q + 7'd1;
	assign fill_pg = base_q + i_q;
	assign in_scope = (i_q < PC'(eff));
	assign walk_last = (i_q + PC'(1) >= PC'(eff));

	// Configuration register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pages_cfg_q <= 7'd64;
		end else if (cfg_we) begin
			pages_cfg_q <= cfg_data;
		end
	end

	// Request capture.
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			req_q <= req;
		end
	end

	// Process table search, one entry a cycle.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pi_q  <= '0;
			hit_q <= 1'b0;
			free_q <= 1'b0;
		end else if (cmd.proc_clr) begin
			pi_q  <= '0;
			hit_q <= 1'b0;
			free_q <= 1'b0;
		end else if (cmd.proc_step) begin
			pi_q <= pi_q + SC'(1);
			if (!hit_q && pvalid_q[ps] && pid_mem_q[ps] == req_q.pid) begin
				hit_q <= 1'b1;
			end
			if (!free_q && !pvalid_q[ps]) begin
				free_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.proc_step) begin
			if (!hit_q && pvalid_q[ps] && pid_mem_q[ps] == req_q.pid) begin
				hit_slot_q  <= ps;
				hit_pages_q <= ppages_q[ps];
			end
			if (!free_q && !pvalid_q[ps]) begin
				free_slot_q <= ps;
			end
		end
	end

	// Process table entries.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pvalid_q <= '0;
		end else if (cmd.commit) begin
			pvalid_q[free_slot_q] <= 1'b1;
		end else if (cmd.rel_commit) begin
			pvalid_q[hit_slot_q] <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.commit) begin
			pid_mem_q[free_slot_q] <= req_q.pid;
			ppages_q[free_slot_q]  <= req_q.page_count;
		end
	end

	// Next page pointer; scan and compaction rewind it after their last page.
	always_comb begin
		i_nxt = i_q;
		if (cmd.page_clr) begin
			i_nxt = '0;
		end else if (cmd.scan_step || cmd.cmp_step) begin
			i_nxt = walk_last ? '0 : i_q + PC'(1);
		end else if (cmd.fill_step || cmd.rel_step || cmd.xl_step) begin
			i_nxt = i_q + PC'(1);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			i_q <= '0;
		end else begin
			i_q <= i_nxt;
		end
	end

	// Registered owner read of the page the pointer moves to.
	always_ff @(posedge clk) begin
		own_rd_q <= owner_q[i_nxt[PW-1:0]];
	end

	// Page walks: scan, compaction, reservation, release and search.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			used_q  <= '0;
			w_q     <= '0;
			run_q   <= '0;
			total_q <= '0;
			found_q <= 1'b0;
			first_q <= 1'b0;
		end else if (cmd.page_clr) begin
			w_q     <= '0;
			run_q   <= '0;
			total_q <= '0;
			found_q <= 1'b0;
			first_q <= 1'b0;
		end else if (cmd.scan_step) begin
			if (in_scope && !used_q[ip]) begin
				run_q   <= run_n;
				total_q <= total_q + 7'd1;
				if (!found_q && run_n >= req_q.page_count) begin
					found_q <= 1'b1;
				end
			end else begin
				run_q <= '0;
			end
		end else if (cmd.cmp_step) begin
			// The run is placed right after the packed pages.
			if (walk_last) begin
				found_q <= 1'b1;
			end
			if (used_q[ip]) begin
				w_q <= w_q + PC'(1);
				if (i_q != w_q) begin
					used_q[w_q[PW-1:0]] <= 1'b1;
					used_q[ip] <= 1'b0;
				end
			end
		end else if (cmd.fill_step) begin
			used_q[fill_pg[PW-1:0]] <= 1'b1;
		end else if (cmd.rel_step) begin
			if (used_q[ip] && own_rd_q == req_q.pid) begin
				used_q[ip] <= 1'b0;
			end
		end else if (cmd.xl_step) begin
			if (!first_q && used_q[ip] && own_rd_q == req_q.pid) begin
				first_q <= 1'b1;
			end
		end
	end

	// Payload side of the page walks.
	always_ff @(posedge clk) begin
		if (cmd.page_clr) begin
			base_q     <= '0;
			first_pg_q <= '0;
		end else if (cmd.scan_step) begin
			if (in_scope && !used_q[ip] && !found_q && run_n >= req_q.page_count) begin
				base_q <= i_q + PC'(1) - PC'(run_n);
			end
		end else if (cmd.cmp_step) begin
			if (used_q[ip]) begin
				base_q <= w_q + PC'(1);
				if (i_q != w_q) begin
					owner_q[w_q[PW-1:0]] <= own_rd_q;
					from_q <= 6'(i_q);
					to_q   <= 6'(w_q);
				end
			end
		end else if (cmd.fill_step) begin
			owner_q[fill_pg[PW-1:0]] <= req_q.pid;
		end else if (cmd.xl_step) begin
			if (!first_q && used_q[ip] && own_rd_q == req_q.pid) begin
				first_pg_q <= i_q;
			end
		end
	end

	// Status back to the controller.
	always_comb begin
		sts.proc_done = (pi_q == SC'(MAX_PROCS));
		sts.proc_hit  = hit_q;
		sts.slot_free = free_q;
		sts.page_done = cmd.scan_step || cmd.cmp_step
			? (i_q + PC'(1) >= PC'(eff))
			: (i_q + PC'(1) >= PC'(NUM_PAGES));
		sts.fit_found = found_q;
		sts.total_ok  = (total_q >= req_q.page_count);
		sts.cnt_zero  = (req_q.page_count == 7'd0);
		sts.fill_done = (7'(i_q) + 7'd1 >= req_q.page_count)
			|| (fill_pg + PC'(1) >= PC'(NUM_PAGES));
		sts.idx_ok    = (7'(req_q.page_index) < hit_pages_q);
		sts.move_now  = cmd.cmp_step && used_q[ip] && (i_q != w_q);
		sts.mode      = req_q.mode;
	end

	assign base_out = (req_q.mode == cpa_pkg::MODE_TRANSLATE)
		? 6'(first_pg_q + PC'(req_q.page_index)) : 6'(base_q);
	assign mv_from = from_q;
	assign mv_to   = to_q;

	// Compaction only ever moves a page downward.
	a_move_down: assert property (@(posedge clk) disable iff (!arst_n)
		sts.move_now |-> (w_q < i_q))
		else $error("compaction moved a page upward");
	// A released entry was found valid.
	a_rel_valid: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.rel_commit |-> pvalid_q[hit_slot_q])
		else $error("release of a free table entry");
	// A new entry goes only into a free slot.
	a_commit_free: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.commit |-> !pvalid_q[free_slot_q])
		else $error("allocation into a used table entry");
endmodule

@@ design/cpa_ctrl.sv @@
module cpa_ctrl (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          in_valid,
	output logic          in_ready,
	output logic          out_valid,
	input  logic          out_ready,
	output cpa_pkg::cmd_t cmd,
	input  cpa_pkg::sts_t sts,
	output logic [1:0]    rsp_status,
	output logic          rsp_move,
	output logic          rsp_base_en
);
	typedef enum logic [9:0] {
		S_IDLE  = 10'b0000000001,
		S_PROC  = 10'b0000000010,
		S_DEC   = 10'b0000000100,
		S_SCAN  = 10'b0000001000,
		S_CMP   = 10'b0000010000,
		S_MOVE  = 10'b0000100000,
		S_FILL  = 10'b0001000000,
		S_REL   = 10'b0010000000,
		S_XL    = 10'b0100000000,
		S_OUT   = 10'b1000000000
	} state_t;

	state_t     state_q;
	state_t     state_d;
	logic [1:0] st_q;
	logic [1:0] st_d;
	logic       base_en_q;
	logic       base_en_d;
	logic       xfer;

	assign xfer = out_valid && out_ready;

	always_comb begin
		state_d   = state_q;
		st_d      = st_q;
		base_en_d = base_en_q;
		cmd       = '0;
		in_ready  = (state_q == S_IDLE);
		out_valid = (state_q == S_OUT) || (state_q == S_MOVE);
		case (state_q)
			S_IDLE: begin
				if (in_valid) begin
					cmd.load     = 1'b1;
					cmd.proc_clr = 1'b1;
					cmd.page_clr = 1'b1;
					state_d      = S_PROC;
				end
			end
			S_PROC: begin
				if (sts.proc_done) begin
					state_d = S_DEC;
				end else begin
					cmd.proc_step = 1'b1;
				end
			end
			S_DEC: begin
				base_en_d = 1'b0;
				st_d      = cpa_pkg::ST_UNKNOWN;
				state_d   = S_OUT;
				case (sts.mode)
					cpa_pkg::MODE_ALLOC: begin
						st_d = cpa_pkg::ST_NO_ROOM;
						if (!sts.proc_hit && sts.slot_free) begin
							if (sts.cnt_zero) begin
								st_d      = cpa_pkg::ST_OK;
								base_en_d = 1'b1;
								cmd.commit = 1'b1;
							end else begin
								state_d = S_SCAN;
							end
						end
					end
					cpa_pkg::MODE_RELEASE: begin
						if (sts.proc_hit) begin
							state_d = S_REL;
						end
					end
					cpa_pkg::MODE_TRANSLATE: begin
						if (sts.proc_hit && sts.idx_ok) begin
							state_d = S_XL;
						end
					end
					default: begin
						state_d = S_OUT;
					end
				endcase
			end
			S_SCAN: begin
				cmd.scan_step = 1'b1;
				if (sts.page_done) begin
					state_d = S_FILL;
				end
			end
			S_CMP: begin
				cmd.cmp_step = 1'b1;
				if (sts.move_now) begin
					state_d = S_MOVE;
				end else if (sts.page_done) begin
					cmd.cmp_step = 1'b1;
					state_d = S_FILL;
				end
			end
			S_MOVE: begin
				// A move on the last page ends the compaction walk.
				if (xfer) begin
					state_d = sts.fit_found ? S_FILL : S_CMP;
				end
			end
			S_FILL: begin
				if (!sts.fit_found && !sts.total_ok) begin
					st_d      = cpa_pkg::ST_NO_ROOM;
					base_en_d = 1'b0;
					state_d   = S_OUT;
				end else if (!sts.fit_found) begin
					// Fall into compaction; fit is declared at its end.
					cmd.page_clr = 1'b1;
					state_d      = S_CMP;
				end else begin
					cmd.fill_step = 1'b1;
					if (sts.fill_done) begin
						cmd.commit = 1'b1;
						st_d       = cpa_pkg::ST_OK;
						base_en_d  = 1'b1;
						state_d    = S_OUT;
					end
				end
			end
			S_REL: begin
				cmd.rel_step = 1'b1;
				if (sts.page_done) begin
					cmd.rel_commit = 1'b1;
					st_d      = cpa_pkg::ST_OK;
					base_en_d = 1'b0;
					state_d   = S_OUT;
				end
			end
			S_XL: begin
				cmd.xl_step = 1'b1;
				if (sts.page_done) begin
					st_d      = cpa_pkg::ST_OK;
					base_en_d = 1'b1;
					state_d   = S_OUT;
				end
			end
			S_OUT: begin
				if (xfer) begin
					state_d = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	assign rsp_status  = (state_q == S_MOVE) ? cpa_pkg::ST_OK : st_q;
	assign rsp_move    = (state_q == S_MOVE);
	assign rsp_base_en = base_en_q && (state_q == S_OUT);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= S_IDLE;
			st_q      <= cpa_pkg::ST_OK;
			base_en_q <= 1'b0;
		end else begin
			state_q   <= state_d;
			st_q      <= st_d;
			base_en_q <= base_en_d;
		end
	end

	// No request is taken while a move result is shown.
	a_move_result: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_MOVE) |-> !in_ready)
		else $error("move shown while accepting input");
	// Intake happens only with no result pending.
	a_one_item: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && in_ready) |=> !out_valid)
		else $error("result shown right after intake");
	// A completed final result returns to idle.
	a_done_idle: assert property (@(posedge clk) disable iff (!arst_n)
		(xfer && state_q == S_OUT) |=> in_ready)
		else $error("controller did not return to idle");
endmodule

@@ dv/contiguous_page_allocator_tb.sv @@
`timescale 1ns / 100ps

module contiguous_page_allocator_tb;

	localparam int NPAGES = 64;
	localparam int NPROCS = 16;
	localparam int DRAIN_CYCLES = 400;

	logic clk;
	logic arst_n;
	logic cfg_we;
	logic [6:0] cfg_data;

	cpa_stream_if #(.W($bits(cpa_pkg::req_t))) req_ch ();
	cpa_stream_if #(.W($bits(cpa_pkg::rsp_t))) rsp_ch ();

	contiguous_page_allocator u_top (
		.clk(clk),
		.arst_n(arst_n),
		.req(req_ch.sink),
		.rsp(rsp_ch.source),
		.cfg_we(cfg_we),
		.cfg_data(cfg_data)
	);

	// Shadow copy of the allocator state.
	logic [6:0] map_size;
	logic       map_used [NPAGES];
	logic [7:0] map_owner [NPAGES];
	logic       tbl_valid [NPROCS];
	logic [7:0] tbl_pid [NPROCS];
	logic [6:0] tbl_pages [NPROCS];

	cpa_pkg::req_t pending_reqs[$];
	cpa_pkg::rsp_t expected_rsps[$];
	int   errors = 0;
	bit   send_on = 1'b1;
	int   burst_left = 0;
	int   gap_left = 0;
	bit   long_hold = 1'b0;
	int   hold_left = 0;

	function automatic cpa_pkg::rsp_t mk_rsp(logic [1:0] st, logic [5:0] base, logic mv,
			logic [5:0] from, logic [5:0] to, logic lst);
		cpa_pkg::rsp_t r;
		r.status = st;
		r.base_page = base;
		r.is_move = mv;
		r.move_from = from;
		r.move_to = to;
		r.last = lst;
		return r;
	endfunction

	function automatic int find_entry(logic [7:0] pid);
		for (int i = 0; i < NPROCS; i++)
			if (tbl_valid[i] && tbl_pid[i] == pid)
				return i;
		return -1;
	endfunction

	// Computes the expected results of one request and updates the shadow state.
	task automatic predict_allocator(cpa_pkg::req_t rq);
		int eff, slot, base, total, ent, w, run, fp, pg;
		bit found;
		eff = (map_size > NPAGES) ? NPAGES : map_size;
		slot = -1;
		base = 0;
		total = 0;
		found = 0;
		case (rq.mode)
			cpa_pkg::MODE_ALLOC: begin
				if (find_entry(rq.pid) >= 0) begin
					expected_rsps.push_back(mk_rsp(cpa_pkg::ST_NO_ROOM, 0, 0, 0, 0, 1));
					return;
				end
				for (int s = NPROCS - 1; s >= 0; s--)
					if (!tbl_valid[s]) slot = s;
				if (slot < 0) begin
					expected_rsps.push_back(mk_rsp(cpa_pkg::ST_NO_ROOM, 0, 0, 0, 0, 1));
					return;
				end
				if (rq.page_count == 0) begin
					found = 1;
				end else begin
					pg = 0;
					while (pg < eff) begin
						if (map_used[pg]) begin
							pg++;
						end else begin
							run = 0;
							while (pg + run < eff && !map_used[pg + run]) run++;
							if (!found && run >= rq.page_count) begin
								found = 1;
								base = pg;
							end
							total += run;
							pg += run;
						end
					end
					if (!found && total >= rq.page_count) begin
						w = 0;
						for (int i = 0; i < eff; i++) begin
							if (map_used[i]) begin
								if (i != w) begin
									map_used[w] = 1;
									map_owner[w] = map_owner[i];
									map_used[i] = 0;
									expected_rsps.push_back(mk_rsp(cpa_pkg::ST_OK, 0, 1,
										6'(i), 6'(w), 0));
								end
								w++;
							end
						end
						base = w;
						found = 1;
					end
				end
				if (!found) begin
					expected_rsps.push_back(mk_rsp(cpa_pkg::ST_NO_ROOM, 0, 0, 0, 0, 1));
					return;
				end
				for (int i = 0; i < rq.page_count && base + i < NPAGES; i++) begin
					map_used[base + i] = 1;
					map_owner[base + i] = rq.pid;
				end
				tbl_valid[slot] = 1;
				tbl_pid[slot] = rq.pid;
				tbl_pages[slot] = rq.page_count;
				expected_rsps.push_back(mk_rsp(cpa_pkg::ST_OK, base[5:0], 0, 0, 0, 1));
			end
			cpa_pkg::MODE_RELEASE: begin
				ent = find_entry(rq.pid);
				if (ent < 0) begin
					expected_rsps.push_back(mk_rsp(cpa_pkg::ST_UNKNOWN, 0, 0, 0, 0, 1));
					return;
				end
				for (int i = 0; i < NPAGES; i++)
					if (map_used[i] && map_owner[i] == rq.pid) map_used[i] = 0;
				tbl_valid[ent] = 0;
				expected_rsps.push_back(mk_rsp(cpa_pkg::ST_OK, 0, 0, 0, 0, 1));
			end
			cpa_pkg::MODE_TRANSLATE: begin
				ent = find_entry(rq.pid);
				if (ent < 0 || rq.page_index >= tbl_pages[ent]) begin
					expected_rsps.push_back(mk_rsp(cpa_pkg::ST_UNKNOWN, 0, 0, 0, 0, 1));
					return;
				end
				fp = -1;
				for (int i = 0; i < NPAGES; i++)
					if (fp < 0 && map_used[i] && map_owner[i] == rq.pid) fp = i;
				if (fp < 0) fp = 0;
				expected_rsps.push_back(mk_rsp(cpa_pkg::ST_OK, 6'(fp + rq.page_index),
					0, 0, 0, 1));
			end
			default: expected_rsps.push_back(mk_rsp(cpa_pkg::ST_UNKNOWN, 0, 0, 0, 0, 1));
		endcase
	endtask

	function automatic cpa_pkg::req_t mk_req(logic [1:0] m, logic [7:0] p, logic [6:0] c,
			logic [5:0] x);
		cpa_pkg::req_t r;
		r.mode = m;
		r.pid = p;
		r.page_count = c;
		r.page_index = x;
		return r;
	endfunction

	// Random request biased toward a small pid pool so requests hit live processes.
	function automatic cpa_pkg::req_t rand_req();
		logic [7:0] p;
		int k;
		k = $urandom_range(0, 99);
		p = ($urandom_range(0, 9) == 0) ? 8'($urandom) : 8'($urandom_range(0, 19));
		if (k < 40)
			return mk_req(cpa_pkg::MODE_ALLOC, p, ($urandom_range(0, 19) == 0) ?
				7'($urandom) : 7'($urandom_range(0, 12)), 6'($urandom));
		else if (k < 65)
			return mk_req(cpa_pkg::MODE_RELEASE, p, 7'($urandom), 6'($urandom));
		else if (k < 97)
			return mk_req(cpa_pkg::MODE_TRANSLATE, p, 7'($urandom),
				($urandom_range(0, 3) == 0) ? 6'($urandom) : 6'($urandom_range(0, 8)));
		else
			return mk_req(2'd3, p, 7'($urandom), 6'($urandom));
	endfunction

	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	initial begin
		#50ms;
		$display("Verification failed");
		$finish;
	end

	// Driver: presents queued requests in bursts with random gaps.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			req_ch.valid <= 1'b0;
			req_ch.data <= '0;
			burst_left <= 0;
			gap_left <= 0;
		end else if (!req_ch.valid || req_ch.ready) begin
			if (req_ch.valid) predict_allocator(cpa_pkg::req_t'(req_ch.data));
			if (gap_left > 0) begin
				gap_left <= gap_left - 1;
				req_ch.valid <= 1'b0;
			end else if (send_on && pending_reqs.size() > 0) begin
				req_ch.valid <= 1'b1;
				req_ch.data <= pending_reqs.pop_front();
				if (burst_left == 0) begin
					burst_left <= $urandom_range(1, 8);
					gap_left <= $urandom_range(0, 1) ? $urandom_range(1, 150) : 0;
				end else begin
					burst_left <= burst_left - 1;
				end
			end else begin
				req_ch.valid <= 1'b0;
			end
		end
	end

	// Receiver stall pattern, with an optional long hold-off.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_ch.ready <= 1'b0;
			hold_left <= 0;
		end else if (long_hold && hold_left == 0) begin
			hold_left <= 2000;
			rsp_ch.ready <= 1'b0;
		end else if (hold_left > 1) begin
			hold_left <= hold_left - 1;
			rsp_ch.ready <= 1'b0;
		end else begin
			if (hold_left == 1) hold_left <= 0;
			rsp_ch.ready <= ($urandom_range(0, 3) != 0) || ($urandom_range(0, 1) == 0);
		end
	end

	// Monitor: checks each result transfer against the oldest expectation.
	always @(posedge clk) begin
		cpa_pkg::rsp_t got, want;
		if (arst_n && rsp_ch.valid && rsp_ch.ready) begin
			got = cpa_pkg::rsp_t'(rsp_ch.data);
			if (expected_rsps.size() == 0) begin
				$error("unexpected result transfer %h", got);
				errors++;
			end else begin
				want = expected_rsps.pop_front();
				if (got.status !== want.status) begin
					$error("status exp %0d got %0d", want.status, got.status); errors++;
				end
				if (got.base_page !== want.base_page) begin
					$error("base_page exp %0d got %0d", want.base_page, got.base_page);
					errors++;
				end
				if (got.is_move !== want.is_move) begin
					$error("is_move exp %0d got %0d", want.is_move, got.is_move); errors++;
				end
				if (got.move_from !== want.move_from) begin
					$error("move_from exp %0d got %0d", want.move_from, got.move_from);
					errors++;
				end
				if (got.move_to !== want.move_to) begin
					$error("move_to exp %0d got %0d", want.move_to, got.move_to); errors++;
				end
				if (got.last !== want.last) begin
					$error("last exp %0d got %0d", want.last, got.last); errors++;
				end
			end
		end
	end

	// Waits until every queued request is taken and all results are back.
	task automatic drain();
		int guard;
		guard = 0;
		while ((pending_reqs.size() > 0 || req_ch.valid || expected_rsps.size() > 0)
				&& guard < 500000) begin
			@(posedge clk);
			guard++;
		end
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	task automatic write_size(logic [6:0] v);
		@(posedge clk);
		cfg_we <= 1'b1;
		cfg_data <= v;
		@(posedge clk);
		cfg_we <= 1'b0;
		map_size = v;
	endtask

	initial begin
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_data = '0;
		map_size = 7'd64;
		for (int i = 0; i < NPAGES; i++) begin
			map_used[i] = 0;
			map_owner[i] = 0;
		end
		for (int i = 0; i < NPROCS; i++) begin
			tbl_valid[i] = 0;
			tbl_pid[i] = 0;
			tbl_pages[i] = 0;
		end
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;

		// Directed: zero pages, holes, compaction, duplicates, unknowns, mode 3.
		write_size(7'd16);
		pending_reqs.push_back(mk_req(cpa_pkg::MODE_ALLOC, 8'd1, 7'd0, 6'd0));
		pending_reqs.push_back(mk_req(cpa_pkg::MODE_TRANSLATE, 8'd1, 7'd0, 6'd0));
		pending_reqs.push_back(mk_req(cpa_pkg::MODE_ALLOC, 8'd2, 7'd4, 6'd0));
		pending_reqs.push_back(mk_req(cpa_pkg::MODE_ALLOC, 8'd3, 7'd4, 6'd0));
		pending_reqs.push_back(mk_req(cpa_pkg::MODE_ALLOC, 8'd4, 7'd4, 6'd0));
		pending_reqs.push_back(mk_req(cpa_pkg::MODE_ALLOC, 8'd2, 7'd1, 6'd0));
		pending_reqs.push_back(mk_req(cpa_pkg::MODE_RELEASE, 8'd3, 7'd0, 6'd0));
		pending_reqs.push_back(mk_req(cpa_pkg::MODE_ALLOC, 8'd5, 7'd8, 6'd0));
		pending_reqs.push_back(mk_req(cpa_pkg::MODE_ALLOC, 8'd6, 7'd17, 6'd0));
		pending_reqs.push_back(mk_req(cpa_pkg::MODE_TRANSLATE, 8'd4, 7'd0, 6'd3));
		pending_reqs.push_back(mk_req(cpa_pkg::MODE_TRANSLATE, 8'd4, 7'd0, 6'd4));
		pending_reqs.push_back(mk_req(cpa_pkg::MODE_TRANSLATE, 8'd99, 7'd0, 6'd63));
		pending_reqs.push_back(mk_req(cpa_pkg::MODE_RELEASE, 8'd255, 7'd127, 6'd63));
		pending_reqs.push_back(mk_req(2'd3, 8'd255, 7'd127, 6'd63));
		drain();

		// Extreme sizes: manages no page, then more than the map holds.
		write_size(7'd0);
		pending_reqs.push_back(mk_req(cpa_pkg::MODE_ALLOC, 8'd7, 7'd1, 6'd0));
		pending_reqs.push_back(mk_req(cpa_pkg::MODE_ALLOC, 8'd8, 7'd0, 6'd0));
		drain();
		write_size(7'd127);
		for (int i = 0; i < 17; i++)
			pending_reqs.push_back(mk_req(cpa_pkg::MODE_ALLOC, 8'(100 + i), 7'd1, 6'd0));
		pending_reqs.push_back(mk_req(cpa_pkg::MODE_TRANSLATE, 8'd100, 7'd0, 6'd0));
		drain();
		for (int i = 0; i < 16; i++)
			pending_reqs.push_back(mk_req(cpa_pkg::MODE_RELEASE, 8'(100 + i), 7'd0, 6'd0));
		pending_reqs.push_back(mk_req(cpa_pkg::MODE_RELEASE, 8'd1, 7'd0, 6'd0));
		drain();

		// Random phases across several map sizes; first one under a long hold-off.
		write_size(7'd64);
		long_hold = 1'b1;
		for (int i = 0; i < 25; i++) pending_reqs.push_back(rand_req());
		wait (hold_left != 0);
		long_hold = 1'b0;
		drain();
		write_size(7'd1);
		for (int i = 0; i < 20; i++) pending_reqs.push_back(rand_req());
		drain();
		write_size(7'd24);
		for (int i = 0; i < 30; i++) pending_reqs.push_back(rand_req());
		drain();
		write_size(7'd64);
		for (int i = 0; i < 30; i++) pending_reqs.push_back(rand_req());
		send_on = 1'b0;
		repeat (3) @(posedge clk);
		send_on = 1'b1;
		drain();

		if (errors == 0 && expected_rsps.size() == 0) begin
			$display("Verification passed");
		end else begin
			$display("Verification failed");
		end
		$finish;
	end

endmodule

@@ files.f @@
design/cpa_pkg.sv
design/cpa_stream_if.sv
design/cpa_datapath.sv
design/cpa_ctrl.sv
design/contiguous_page_allocator.sv
dv/contiguous_page_allocator_tb.sv
